// ===== design/isqrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isqrt_pkg: shared types and constants of the inverse square root unit
// Word types, the field prime, sqrt(-1) and the addition chain tables.
// ----------------------------------------------------------------------------
package isqrt_pkg;

	localparam int LIMB_W  = 51;
	localparam int FE_W    = 255;
	localparam int CHAIN_N = 12;

	typedef struct packed {
		logic [LIMB_W-1:0] value_limb4;
		logic [LIMB_W-1:0] value_limb3;
		logic [LIMB_W-1:0] value_limb2;
		logic [LIMB_W-1:0] value_limb1;
		logic [LIMB_W-1:0] value_limb0;
	} value_t;

	typedef struct packed {
		logic [LIMB_W-1:0] root_limb4;
		logic [LIMB_W-1:0] root_limb3;
		logic [LIMB_W-1:0] root_limb2;
		logic [LIMB_W-1:0] root_limb1;
		logic [LIMB_W-1:0] root_limb0;
	} root_t;

	localparam logic [FE_W-1:0] PRIME = {{(FE_W-5){1'b1}}, 5'b01101};

	localparam logic [FE_W-1:0] ROOT_M1 = {51'h2b8324804fc1d, 51'h78595a6804c9e,
		51'h7ef5e9cbd0c60, 51'h0d5a5fc8f189d, 51'h61b274a0ea0b0};

	// Number of squarings in each chain step.
	function automatic logic [6:0] chain_sh(input logic [3:0] i);
		logic [6:0] r;
		case (i)
			4'd0: r = 7'd1;
			4'd1: r = 7'd1;
			4'd2: r = 7'd3;
			4'd3: r = 7'd6;
			4'd4: r = 7'd1;
			4'd5: r = 7'd12;
			4'd6: r = 7'd25;
			4'd7: r = 7'd25;
			4'd8: r = 7'd50;
			4'd9: r = 7'd125;
			4'd10: r = 7'd2;
			default: r = 7'd1;
		endcase
		return r;
	endfunction

	// Which stored value multiplies in after the squarings.
	function automatic logic [1:0] chain_ix(input logic [3:0] i);
		logic [1:0] r;
		case (i)
			4'd2, 4'd5, 4'd6, 4'd7: r = 2'd1;
			4'd3, 4'd8, 4'd9: r = 2'd0;
			default: r = 2'd2;
		endcase
		return r;
	endfunction

	// Brings a value below 2*p into the range [0, p).
	function automatic logic [FE_W-1:0] canon(input logic [FE_W:0] v);
		logic [FE_W+1:0] d;
		d = {1'b0, v} - {2'b00, PRIME};
		return d[FE_W+1] ? v[FE_W-1:0] : d[FE_W-1:0];
	endfunction

endpackage

// ===== design/inverse_sqrt_mod_p25519_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverse_sqrt_mod_p25519_unit: inverse square root modulo 2^255-19
// Raises x through a fixed addition chain on one digit-serial multiplier.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. The canonical result a,
// with a^2*x in {0, 1, sqrt(-1)}, is shown on root for exactly one cycle with
// done high, once the chain and, when it is needed, the final multiplication
// by sqrt(-1) are through. The receiver cannot stall it, so it must take the
// word in that cycle. Busy stays high from acceptance through the done cycle.
// The run time is set by the single modular multiplier, which consumes the
// multiplier operand four bits per cycle. Each product passes through a launch
// state, one digit step per four-bit digit, a reduction step and the state in
// which the sequencer takes the product. Each of the 12 chain steps also has a
// preparation state, and the final check has a state of its own. The chain
// uses 252 squarings and 12 multiplications, with one more multiplication by
// sqrt(-1) when needed, for 264 or 265 products per word.
module inverse_sqrt_mod_p25519_unit
	import isqrt_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  value_t value,
	output logic   busy,
	output logic   done,
	output root_t  root
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_PREP = 4'd1;
	localparam logic [3:0] ST_SQ   = 4'd2;
	localparam logic [3:0] ST_WSQ  = 4'd3;
	localparam logic [3:0] ST_MUL  = 4'd4;
	localparam logic [3:0] ST_WM   = 4'd5;
	localparam logic [3:0] ST_CHK  = 4'd6;
	localparam logic [3:0] ST_WF   = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;

	localparam int DIG_W  = 4;
	localparam int DIGITS = 64;

	logic [3:0] state_q;
	logic [3:0] step_q;
	logic [6:0] sq_cnt_q;

	// Chain values: st0 and st1 alternate as the step outputs, x stays fixed.
	logic [FE_W-1:0] x_q, st0_q, st1_q, tmp_q, out_q;

	// Multiplier state.
	logic            mul_busy_q, mul_done_q;
	logic [6:0]      mul_cnt_q;
	logic [FE_W-1:0] mul_a_q, mul_res_q;
	logic [FE_W:0]   mul_b_q;
	logic [FE_W:0]   acc_q;

	logic            go;
	logic [FE_W-1:0] op_a, op_b, sel_v;
	logic            hit;
	logic [FE_W+5:0] t_sum;
	logic [FE_W:0]   acc_next;
	logic [10:0]     fold;

	always_comb begin
		case (chain_ix(step_q))
			2'd0: sel_v = st0_q;
			2'd1: sel_v = st1_q;
			default: sel_v = x_q;
		endcase
	end

	assign hit = (st1_q == {{(FE_W-1){1'b0}}, 1'b1}) || (st1_q == ROOT_M1);

	always_comb begin
		go   = 1'b0;
		op_a = tmp_q;
		op_b = tmp_q;
		case (state_q)
			ST_SQ: go = 1'b1;
			ST_MUL: begin
				go   = 1'b1;
				op_b = sel_v;
			end
			ST_CHK: begin
				go   = !hit;
				op_a = ROOT_M1;
				op_b = st0_q;
			end
			default: go = 1'b0;
		endcase
	end

	// One digit step: acc*16 + a*digit, with bits from 255 up folded back as *19.
	always_comb begin
		t_sum = {1'b0, acc_q, {DIG_W{1'b0}}}
			+ (FE_W+6)'(mul_a_q) * (FE_W+6)'(mul_b_q[FE_W:FE_W-DIG_W+1]);
		fold     = 11'(t_sum[FE_W+5:FE_W]) * 11'd19;
		acc_next = {1'b0, t_sum[FE_W-1:0]} + (FE_W+1)'(fold);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			mul_done_q <= 1'b0;
			mul_cnt_q  <= '0;
		end else begin
			mul_done_q <= 1'b0;
			if (go) begin
				mul_busy_q <= 1'b1;
				mul_cnt_q  <= '0;
			end else if (mul_busy_q) begin
				if (mul_cnt_q == 7'(DIGITS)) begin
					mul_busy_q <= 1'b0;
					mul_done_q <= 1'b1;
				end else begin
					mul_cnt_q <= mul_cnt_q + 7'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			mul_a_q <= op_a;
			mul_b_q <= {1'b0, op_b};
			acc_q   <= '0;
		end else if (mul_busy_q) begin
			if (mul_cnt_q == 7'(DIGITS)) begin
				mul_res_q <= canon(acc_q);
			end else begin
				acc_q   <= acc_next;
				mul_b_q <= {mul_b_q[FE_W-DIG_W:0], {DIG_W{1'b0}}};
			end
		end
	end

	// Chain sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			sq_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_PREP;
						step_q  <= '0;
					end
				end
				ST_PREP: begin
					sq_cnt_q <= '0;
					state_q  <= ST_SQ;
				end
				ST_SQ: state_q <= ST_WSQ;
				ST_WSQ: begin
					if (mul_done_q) begin
						sq_cnt_q <= sq_cnt_q + 7'd1;
						state_q  <= (sq_cnt_q + 7'd1 == chain_sh(step_q)) ? ST_MUL : ST_SQ;
					end
				end
				ST_MUL: state_q <= ST_WM;
				ST_WM: begin
					if (mul_done_q) begin
						if (step_q == 4'(CHAIN_N - 1)) begin
							state_q <= ST_CHK;
						end else begin
							step_q  <= step_q + 4'd1;
							state_q <= ST_PREP;
						end
					end
				end
				ST_CHK: state_q <= hit ? ST_OUT : ST_WF;
				ST_WF: begin
					if (mul_done_q) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					x_q   <= canon({1'b0, value});
					st0_q <= canon({1'b0, value});
					st1_q <= canon({1'b0, value});
				end
			end
			ST_PREP: tmp_q <= step_q[0] ? st0_q : st1_q;
			ST_WSQ: begin
				if (mul_done_q) begin
					tmp_q <= mul_res_q;
				end
			end
			ST_WM: begin
				if (mul_done_q) begin
					if (step_q[0]) begin
						st1_q <= mul_res_q;
					end else begin
						st0_q <= mul_res_q;
					end
				end
			end
			ST_CHK: out_q <= st0_q;
			ST_WF: begin
				if (mul_done_q) begin
					out_q <= mul_res_q;
				end
			end
			default: out_q <= out_q;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_OUT);
	assign root = root_t'(out_q);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done without busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted word did not raise busy");
	a_mul_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		mul_busy_q |-> (mul_cnt_q <= 7'(DIGITS))) else $error("digit count overrun");
	a_mul_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_busy_q |-> (state_q == ST_WSQ || state_q == ST_WM || state_q == ST_WF))
		else $error("multiplier busy outside a wait state");

endmodule
